// ===== hdl/mmpp_pkg.sv =====
package mmpp_pkg;

  localparam int VERTICES = 16;
  localparam int VB       = $clog2(VERTICES);
  localparam int ADDR_W   = 2 * VB;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  localparam int CMD_W     = 2;
  localparam int FIELD_W   = 4;
  localparam int WEIGHT_W  = 16;
  localparam int VALUE_W   = 24;
  localparam int DEGREE_W  = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = DEGREE_W;

  typedef logic [VB-1:0]       idx_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  localparam idx_t   IDX_LAST  = VB'(VERTICES - 1);
  localparam value_t VALUE_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POWER_DEGREE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_MODE    = 1'b1;

  localparam logic MODE_SHORTEST = 1'b0;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_LOAD,
    S_LOAD_END,
    S_MULT,
    S_MULT_END,
    S_COPY,
    S_COPY_END,
    S_DONE
  } state_t;

  // Map a 4-bit vertex field onto the internal index width.
  function automatic idx_t to_idx(input logic [FIELD_W-1:0] v);
    logic [VB+FIELD_W-1:0] ext;
    ext = {{VB{1'b0}}, v};
    return ext[VB-1:0];
  endfunction

  function automatic logic in_range(input logic [FIELD_W-1:0] v);
    logic [VB+FIELD_W-1:0] ext;
    ext = {{VB{1'b0}}, v};
    return ext < (VB + FIELD_W)'(VERTICES);
  endfunction

endpackage

// ===== hdl/mmpp_ram.sv =====
module mmpp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mmpp_acc.sv =====
module mmpp_acc (
  input  logic             clk,
  input  logic             en,
  input  logic             first,
  input  logic             mode,
  input  mmpp_pkg::value_t a,
  input  mmpp_pkg::weight_t b,
  output mmpp_pkg::value_t result,
  output logic             sat_hit
);
  import mmpp_pkg::*;

  value_t               best_r;
  logic                 found_r;
  value_t               best_nxt;
  logic                 found_nxt;
  logic [VALUE_W:0]     sum;
  value_t               cand;
  logic                 has_cand;
  value_t               cur_best;
  logic                 cur_found;
  logic                 better;

  always_comb begin
    cur_best  = first ? '0 : best_r;
    cur_found = first ? 1'b0 : found_r;
    has_cand  = (a != '0) && (b != '0);
    sum       = {1'b0, a} + (VALUE_W + 1)'(b);
    cand      = sum[VALUE_W] ? VALUE_MAX : sum[VALUE_W-1:0];
    better    = (mode == MODE_SHORTEST) ? (cand < cur_best) : (cand > cur_best);
    best_nxt  = cur_best;
    found_nxt = cur_found;
    if (has_cand && (!cur_found || better)) begin
      best_nxt  = cand;
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      best_r  <= best_nxt;
      found_r <= found_nxt;
    end
  end

  // No candidate leaves best at zero, which is the no-path code.
  assign result  = best_nxt;
  assign sat_hit = en && has_cand && sum[VALUE_W];

endmodule

// ===== hdl/min_max_plus_matrix_power_unit.sv =====
// Write items: one per cycle while the output does not stall, result registered in the cycle after the transfer.
// Read items: a registered memory read, then one result transfer.
// Run items: a load sweep, then max(degree,1)-1 rounds of multiply and copy
// sweeps; one shared add/saturate/compare unit handles one k term per cycle.
// Reset: synchronous, active low; afterward a clearing pass zeroes the adjacency
// and power memories while input stays stalled (config is taken).
module min_max_plus_matrix_power_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mmpp_pkg::CMD_W-1:0]          in_cmd,
  input  logic [mmpp_pkg::FIELD_W-1:0]        in_row,
  input  logic [mmpp_pkg::FIELD_W-1:0]        in_col,
  input  logic [mmpp_pkg::WEIGHT_W-1:0]       in_weight,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mmpp_pkg::VALUE_W-1:0]        out_value,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mmpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmpp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import mmpp_pkg::*;

  state_t state_r, state_nxt;

  // sweep counters: i row, j column, k inner term
  idx_t i_r, j_r, k_r;
  idx_t i_nxt, j_nxt, k_nxt;
  logic issue;
  logic sweep_mult;
  logic sweep_last;

  // configuration
  logic [DEGREE_W-1:0] degree_r;
  logic                mode_r;

  // run bookkeeping
  logic [DEGREE_W-1:0] iter_r;
  logic                sat_flag_r;
  logic                rd_ok_r;

  // second stage of the sweep pipeline (memory data arrives here)
  logic  pv_r, pfirst_r, plast_r;
  addr_t paddr_r;

  // memory ports
  logic    adj_we;
  addr_t   adj_waddr, adj_raddr;
  weight_t adj_wdata, adj_rdata;
  logic    pow_we;
  addr_t   pow_waddr, pow_raddr;
  value_t  pow_wdata, pow_rdata;
  logic    scr_we;
  addr_t   scr_waddr, scr_raddr;
  value_t  scr_wdata, scr_rdata;

  // shared semiring unit
  logic   acc_en;
  value_t acc_result;
  logic   acc_sat;

  // result register
  logic   out_valid_r;
  value_t out_value_r;
  logic   out_saturated_r;
  logic   deposit;
  value_t deposit_value;

  logic in_fire;
  logic run_start;
  idx_t in_r_idx, in_c_idx;
  logic in_ok;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign run_start = in_fire && (in_cmd == CMD_RUN);
  assign in_r_idx  = to_idx(in_row);
  assign in_c_idx  = to_idx(in_col);
  assign in_ok     = in_range(in_row) && in_range(in_col);

  assign cfg_ready = 1'b1;

  assign sweep_last = (i_r == IDX_LAST) && (j_r == IDX_LAST) &&
                      (!sweep_mult || (k_r == IDX_LAST));

  //--------------------------------------------------------------------------
  // Next state
  //--------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_READ: state_nxt = S_READ;
            CMD_RUN:  state_nxt = S_LOAD;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ:     state_nxt = S_IDLE;
      S_LOAD: begin
        if (sweep_last) state_nxt = S_LOAD_END;
      end
      S_LOAD_END: state_nxt = (iter_r == '0) ? S_DONE : S_MULT;
      S_MULT: begin
        if (sweep_last) state_nxt = S_MULT_END;
      end
      S_MULT_END: state_nxt = S_COPY;
      S_COPY: begin
        if (sweep_last) state_nxt = S_COPY_END;
      end
      S_COPY_END: state_nxt = (iter_r == '0) ? S_DONE : S_MULT;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  //--------------------------------------------------------------------------
  // Outputs of the sequencer: memory ports, sweep control, result deposit
  //--------------------------------------------------------------------------
  always_comb begin
    issue         = 1'b0;
    sweep_mult    = 1'b0;
    adj_we        = 1'b0;
    adj_waddr     = {i_r, j_r};
    adj_wdata     = '0;
    adj_raddr     = {i_r, j_r};
    pow_we        = 1'b0;
    pow_waddr     = paddr_r;
    pow_wdata     = '0;
    pow_raddr     = {i_r, k_r};
    scr_we        = 1'b0;
    scr_waddr     = paddr_r;
    scr_wdata     = acc_result;
    scr_raddr     = {i_r, j_r};
    acc_en        = 1'b0;
    deposit       = 1'b0;
    deposit_value = '0;
    case (state_r)
      S_CLEAR: begin
        // zero both stores one cell a cycle
        issue     = 1'b1;
        adj_we    = 1'b1;
        pow_we    = 1'b1;
        pow_waddr = {i_r, j_r};
      end
      S_IDLE: begin
        pow_raddr = {in_r_idx, in_c_idx};
        if (in_fire) begin
          case (in_cmd)
            CMD_WRITE: begin
              adj_we    = in_ok;
              adj_waddr = {in_r_idx, in_c_idx};
              adj_wdata = in_weight;
              deposit   = 1'b1;
            end
            CMD_READ: deposit = 1'b0;
            CMD_RUN:  deposit = 1'b0;
            default:  deposit = 1'b1;
          endcase
        end
      end
      S_READ: begin
        deposit       = 1'b1;
        deposit_value = rd_ok_r ? pow_rdata : '0;
      end
      S_LOAD, S_LOAD_END: begin
        issue     = (state_r == S_LOAD);
        pow_we    = pv_r;
        pow_wdata = VALUE_W'(adj_rdata);
      end
      S_MULT, S_MULT_END: begin
        issue      = (state_r == S_MULT);
        sweep_mult = 1'b1;
        adj_raddr  = {k_r, j_r};
        acc_en     = pv_r;
        scr_we     = pv_r && plast_r;
      end
      S_COPY, S_COPY_END: begin
        issue     = (state_r == S_COPY);
        pow_we    = pv_r;
        pow_wdata = scr_rdata;
      end
      S_DONE:  deposit = 1'b1;
      default: deposit = 1'b0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Sweep counters: k innermost during multiply, else j then i
  //--------------------------------------------------------------------------
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (issue) begin
      if (sweep_mult && (k_r != IDX_LAST)) begin
        k_nxt = k_r + 1'b1;
      end else begin
        k_nxt = '0;
        if (j_r != IDX_LAST) begin
          j_nxt = j_r + 1'b1;
        end else begin
          j_nxt = '0;
          i_nxt = (i_r == IDX_LAST) ? '0 : i_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      i_r             <= '0;
      j_r             <= '0;
      k_r             <= '0;
      pv_r            <= 1'b0;
      degree_r        <= DEGREE_W'(1);
      mode_r          <= MODE_SHORTEST;
      iter_r          <= '0;
      sat_flag_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      pv_r    <= issue && (state_r != S_CLEAR);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POWER_DEGREE: degree_r <= cfg_wdata;
          CFG_PATH_MODE:    mode_r   <= cfg_wdata[0];
          default:          mode_r   <= mode_r;
        endcase
      end

      // degree zero acts like one: copy only
      if (run_start) begin
        iter_r <= (degree_r <= DEGREE_W'(1)) ? '0 : degree_r - 1'b1;
      end else if (state_r == S_MULT_END) begin
        iter_r <= iter_r - 1'b1;
      end

      if (run_start) begin
        sat_flag_r <= 1'b0;
      end else if (acc_sat) begin
        sat_flag_r <= 1'b1;
      end

      // hold a stalled result, drop it once transferred
      if (deposit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pfirst_r <= (k_r == '0);
    plast_r  <= (k_r == IDX_LAST);
    paddr_r  <= {i_r, j_r};
    if (in_fire) begin
      rd_ok_r <= in_ok;
    end
    if (deposit) begin
      out_value_r     <= deposit_value;
      out_saturated_r <= sat_flag_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_saturated_r;

  //--------------------------------------------------------------------------
  // Stores and the shared unit
  //--------------------------------------------------------------------------
  mmpp_ram #(.WIDTH(WEIGHT_W), .DEPTH(RAM_DEPTH)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  mmpp_ram #(.WIDTH(VALUE_W), .DEPTH(RAM_DEPTH)) u_pow_ram (
    .clk   (clk),
    .we    (pow_we),
    .waddr (pow_waddr),
    .wdata (pow_wdata),
    .raddr (pow_raddr),
    .rdata (pow_rdata)
  );

  mmpp_ram #(.WIDTH(VALUE_W), .DEPTH(RAM_DEPTH)) u_scr_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  mmpp_acc u_acc (
    .clk     (clk),
    .en      (acc_en),
    .first   (pfirst_r),
    .mode    (mode_r),
    .a       (pow_rdata),
    .b       (adj_rdata),
    .result  (acc_result),
    .sat_hit (acc_sat)
  );

  //--------------------------------------------------------------------------
  // Checks
  //--------------------------------------------------------------------------
  // A result is only placed into an empty or draining output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    deposit |-> !(out_valid_r && out_stall))
    else $error("result deposited over a pending result");

  // Sweep counters are back at zero whenever no sweep is running.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (i_r == '0 && j_r == '0 && k_r == '0))
    else $error("sweep counters not at zero while idle");

  // Second pipeline stage is only live inside a load, multiply or copy sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == S_LOAD || state_r == S_LOAD_END || state_r == S_MULT ||
              state_r == S_MULT_END || state_r == S_COPY || state_r == S_COPY_END))
    else $error("pipeline stage live outside a sweep");

  // Saturation flag clears only at the start of a run.
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(sat_flag_r) |-> $past(run_start))
    else $error("saturation flag cleared outside run start");

endmodule
